[hw/rtl/ibp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ibp_pkg;

    localparam int LANES     = 8;
    localparam int WORD_BITS = 32;
    localparam int SH_W      = $clog2(WORD_BITS);
    localparam int WIDTH_W   = 6;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic [31:0] value_lane0;
        logic [31:0] value_lane1;
        logic [31:0] value_lane2;
        logic [31:0] value_lane3;
        logic [31:0] value_lane4;
        logic [31:0] value_lane5;
        logic [31:0] value_lane6;
        logic [31:0] value_lane7;
    } t_in;

    typedef struct packed {
        logic [31:0] word_lane0;
        logic [31:0] word_lane1;
        logic [31:0] word_lane2;
        logic [31:0] word_lane3;
        logic [31:0] word_lane4;
        logic [31:0] word_lane5;
        logic [31:0] word_lane6;
        logic [31:0] word_lane7;
        logic        block_last;
    } t_out;

    // Per-beat decisions made by the front, carried out by the back
    typedef struct packed {
        logic [SH_W-1:0] shift;     // bit position of the value in the accumulator
        logic            emit;      // accumulator is complete after this beat
        logic            carry_en;  // high bits spill into the next word
        logic [SH_W-1:0] carry_sh;  // right shift that leaves the spilled bits
        logic            last;      // beat closes a 256-value block
    } t_ctrl;

    typedef struct packed {
        t_ctrl                     ctrl;
        logic [LANES*WORD_BITS-1:0] vals;  // masked values, lane 0 in the low word
    } t_cmd;

    function automatic logic [LANES*WORD_BITS-1:0] flatten_in(input t_in d);
        flatten_in = {d.value_lane7, d.value_lane6, d.value_lane5, d.value_lane4,
                      d.value_lane3, d.value_lane2, d.value_lane1, d.value_lane0};
    endfunction

    function automatic t_out build_out(input logic [LANES*WORD_BITS-1:0] w,
                                       input logic last);
        t_out o;
        o.word_lane0 = w[0*WORD_BITS +: WORD_BITS];
        o.word_lane1 = w[1*WORD_BITS +: WORD_BITS];
        o.word_lane2 = w[2*WORD_BITS +: WORD_BITS];
        o.word_lane3 = w[3*WORD_BITS +: WORD_BITS];
        o.word_lane4 = w[4*WORD_BITS +: WORD_BITS];
        o.word_lane5 = w[5*WORD_BITS +: WORD_BITS];
        o.word_lane6 = w[6*WORD_BITS +: WORD_BITS];
        o.word_lane7 = w[7*WORD_BITS +: WORD_BITS];
        o.block_last = last;
        build_out = o;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/interleaved_bit_packer_8lane.sv]
// Eight-lane bit packer: each accepted beat carries eight 32-bit values; each is cut to
// the configured width and appended to its lane's 32-bit word, and when the words fill
// up one beat of eight packed words leaves the output queue (block_last marks the word
// that closes a 256-value block). Width 0 drops every beat, widths of 32 and above pass
// values unchanged. One beat is taken per clock while full is low; a result is registered
// in the command queue and then in the output queue before it appears on the output.
// The pace is set by the single shift-and-OR stage per lane
// and the two 2-entry queues, between front and back and at the output, which let
// input and output stall independently. Writing the width register restarts the block;
// write it only with the block drained. The configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module interleaved_bit_packer_8lane (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire ibp_pkg::t_in  i_item,
    output logic               empty,
    input  wire logic          pop,
    output ibp_pkg::t_out      o_item,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [5:0]    i_cfg_data
);
    import ibp_pkg::*;

    t_cmd front_cmd, q_cmd;
    logic front_push, q_empty, q_pop, cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    ibp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_q_full   (full),
        .i_item     (i_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (front_cmd),
        .o_cmd_push (front_push)
    );

    ibp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    ibp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (cfg_we),
        .i_cmd_empty (q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire

[hw/rtl/ibp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ibp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_q_full,
    input  wire ibp_pkg::t_in      i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [5:0]        i_cfg_data,
    output ibp_pkg::t_cmd          o_cmd,
    output logic                   o_cmd_push
);
    import ibp_pkg::*;

    logic [WIDTH_W-1:0] r_width, n_width;
    logic [SH_W-1:0]    r_shift, n_shift;
    logic [SH_W-1:0]    r_group, n_group;

    logic               acc;
    logic [WIDTH_W-1:0] w;
    logic [WIDTH_W:0]   total;
    logic [SH_W-1:0]    rest;
    logic [WIDTH_W-1:0] carry_sh;
    t_word              mask;
    logic [LANES*WORD_BITS-1:0] raw;

    assign acc = i_push && !i_q_full;

    // Saturate the width register at one full word
    assign w = (r_width > WIDTH_W'(WORD_BITS)) ? WIDTH_W'(WORD_BITS) : r_width;

    // Classify the beat: where it lands and whether the word fills up
    always_comb begin
        total    = {2'b00, r_shift} + {1'b0, w};
        rest     = total[SH_W-1:0];
        carry_sh = w - {1'b0, rest};
        mask     = ~({WORD_BITS{1'b1}} << w);
        raw      = flatten_in(i_item);
        o_cmd.ctrl.shift    = r_shift;
        o_cmd.ctrl.emit     = (total >= (WIDTH_W+1)'(WORD_BITS));
        o_cmd.ctrl.carry_en = (rest != '0);
        o_cmd.ctrl.carry_sh = carry_sh[SH_W-1:0];
        o_cmd.ctrl.last     = (r_group == {SH_W{1'b1}});
        for (int k = 0; k < LANES; k++) begin
            o_cmd.vals[k*WORD_BITS +: WORD_BITS] = raw[k*WORD_BITS +: WORD_BITS] & mask;
        end
    end

    // Width zero produces nothing, so it never reaches the back
    assign o_cmd_push = acc && (w != '0);

    // Advance fill level and block position; a register write restarts the block
    always_comb begin
        n_width = r_width;
        n_shift = r_shift;
        n_group = r_group;
        if (i_cfg_we) begin
            n_width = i_cfg_data;
            n_shift = '0;
            n_group = '0;
        end else if (acc) begin
            n_group = r_group + 1'b1;
            if (w != '0) begin
                n_shift = o_cmd.ctrl.emit ? rest : total[SH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
            r_shift <= '0;
            r_group <= '0;
        end else begin
            r_width <= n_width;
            r_shift <= n_shift;
            r_group <= n_group;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ibp_cmd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ibp_cmd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ibp_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output ibp_pkg::t_cmd       o_cmd
);
    import ibp_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ibp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ibp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_clr,
    input  wire logic           i_cmd_empty,
    input  wire ibp_pkg::t_cmd  i_cmd,
    output logic                o_cmd_pop,
    output logic                o_empty,
    input  wire logic           i_pop,
    output ibp_pkg::t_out       o_item
);
    import ibp_pkg::*;

    t_word                      r_acc [LANES];
    logic [LANES*WORD_BITS-1:0] merged;
    t_out                       r_oq [2];
    logic                       r_wr, r_rd;
    logic [1:0]                 r_cnt, n_cnt;
    logic                       oq_full, do_emit, do_pop;

    assign oq_full   = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_cmd_pop = !i_cmd_empty && (!i_cmd.ctrl.emit || !oq_full);
    assign do_emit   = o_cmd_pop && i_cmd.ctrl.emit;
    assign do_pop    = i_pop && !o_empty;
    assign o_item    = r_oq[r_rd];

    // Per lane shift-and-OR into the accumulator, keep the spill on a full word
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        t_word v;
        assign v = i_cmd.vals[k*WORD_BITS +: WORD_BITS];
        assign merged[k*WORD_BITS +: WORD_BITS] = r_acc[k] | (v << i_cmd.ctrl.shift);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_clr) begin
                r_acc[k] <= '0;
            end else if (o_cmd_pop) begin
                if (!i_cmd.ctrl.emit) begin
                    r_acc[k] <= merged[k*WORD_BITS +: WORD_BITS];
                end else if (i_cmd.ctrl.carry_en) begin
                    r_acc[k] <= v >> i_cmd.ctrl.carry_sh;
                end else begin
                    r_acc[k] <= '0;
                end
            end
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (do_emit && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_emit) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Hold finished beats until taken
    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_oq[r_wr] <= build_out(merged, i_cmd.ctrl.last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_emit) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ibp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ibp_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    input  wire logic          full,
    input  wire logic          empty,
    input  wire logic          pop,
    input  wire ibp_pkg::t_out o_item
);

    // Reset drains both sides
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output queue not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    // Back-pressure on the input only builds up behind a waiting result
    a_full_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input full while no result is waiting");

    // A waiting result holds until popped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("waiting result changed before pop");

endmodule

bind interleaved_bit_packer_8lane ibp_checker u_ibp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);

`default_nettype wire
